// ===== rtl/bsm_pkg.sv =====
`timescale 1ns / 1ps
// bsm_pkg: shared default width constant, booth recoding type and decode function
// no dependencies; imported by the interfaces, the step stage and the top level
package bsm_pkg;

  // default operand width
  localparam int unsigned BSM_WIDTH_DEF = 8;

  // radix-2 booth recoding of the pair {current bit, previous bit}
  typedef enum logic [1:0] {
    BOOTH_NOP = 2'd0,
    BOOTH_ADD = 2'd1,
    BOOTH_SUB = 2'd2
  } booth_op_t;

  function automatic booth_op_t booth_decode(input logic cur, input logic prev);
    booth_op_t op;
    case ({cur, prev})
      2'b01:   op = BOOTH_ADD;
      2'b10:   op = BOOTH_SUB;
      default: op = BOOTH_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/bsm_in_if.sv =====
`timescale 1ns / 1ps
// bsm_in_if: operand channel, valid/ready plus multiplicand and multiplier
// depends on bsm_pkg for the default width
interface bsm_in_if
  import bsm_pkg::*;
#(
  parameter int unsigned WIDTH = BSM_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] multiplicand;
  logic signed [WIDTH-1:0] multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

// ===== rtl/bsm_out_if.sv =====
`timescale 1ns / 1ps
// bsm_out_if: product channel, valid/ready plus the 2*WIDTH-bit product
// depends on bsm_pkg for the default width
interface bsm_out_if
  import bsm_pkg::*;
#(
  parameter int unsigned WIDTH = BSM_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [2*WIDTH-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

// ===== rtl/booth_signed_multiplier.sv =====
`timescale 1ns / 1ps
// booth_signed_multiplier: radix-2 booth signed multiplier, one booth step per stage
// throughput: one operand pair per cycle while out_ch.ready is high
// each of the WIDTH step stages holds one item
// the per-stage cost is one (WIDTH+1)-bit add or subtract
// reset: rst_n synchronous active low clears every stage valid bit, payload is not reset
// depends on bsm_pkg, bsm_in_if, bsm_out_if and bsm_stage
module booth_signed_multiplier
  import bsm_pkg::*;
#(
  parameter int unsigned WIDTH = BSM_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bsm_in_if.sink    in_ch,
  bsm_out_if.source out_ch
);

  // stage k holds the acc:q pair after k+1 booth steps
  // index 0 of these arrays is the pipeline head, fed straight from the input channel
  logic                    valid_s [WIDTH+1];
  logic                    ready_s [WIDTH+1];
  logic signed [WIDTH:0]   acc_s   [WIDTH+1];
  logic        [WIDTH-1:0] q_s     [WIDTH+1];
  logic                    prev_s  [WIDTH+1];
  logic signed [WIDTH-1:0] mcand_s [WIDTH+1];

  // head: accumulator cleared, multiplier in the low half, implied previous bit zero
  assign valid_s[0]   = in_ch.valid;
  assign acc_s[0]     = '0;
  assign q_s[0]       = in_ch.multiplier;
  assign prev_s[0]    = 1'b0;
  assign mcand_s[0]   = in_ch.multiplicand;
  assign in_ch.ready  = ready_s[0];

  // chain of booth steps, each a register stage with its own valid bit
  // a stage refills as soon as its content moves on, so bubbles collapse on a stall
  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    bsm_stage #(
      .WIDTH (WIDTH)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .acc_i   (acc_s[k]),
      .q_i     (q_s[k]),
      .prev_i  (prev_s[k]),
      .mcand_i (mcand_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .acc_o   (acc_s[k+1]),
      .q_o     (q_s[k+1]),
      .prev_o  (prev_s[k+1]),
      .mcand_o (mcand_s[k+1])
    );
  end

  // last stage register doubles as the output register
  assign ready_s[WIDTH] = out_ch.ready;
  assign out_ch.valid   = valid_s[WIDTH];
  // product is the low WIDTH bits of the accumulator over the shifted-out q bits
  assign out_ch.product = {acc_s[WIDTH][WIDTH-1:0], q_s[WIDTH]};

  // prev bit, accumulator sign bit and multiplicand leave the last stage unused
  logic                    unused_tail;
  assign unused_tail = prev_s[WIDTH] ^ acc_s[WIDTH][WIDTH] ^ (^mcand_s[WIDTH]);

endmodule

// ===== rtl/bsm_stage.sv =====
`timescale 1ns / 1ps
// bsm_stage: one registered booth step (add/sub, then arithmetic shift right)
// depends on bsm_pkg for the recoding type and decode function
module bsm_stage
  import bsm_pkg::*;
#(
  parameter int unsigned WIDTH = BSM_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // upstream side
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [WIDTH:0]   acc_i,
  input  logic        [WIDTH-1:0] q_i,
  input  logic                    prev_i,
  input  logic signed [WIDTH-1:0] mcand_i,
  // downstream side
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [WIDTH:0]   acc_o,
  output logic        [WIDTH-1:0] q_o,
  output logic                    prev_o,
  output logic signed [WIDTH-1:0] mcand_o
);

  logic                    valid_r;
  logic signed [WIDTH:0]   acc_r, acc_nxt;
  logic        [WIDTH-1:0] q_r, q_nxt;
  logic                    prev_r;
  logic signed [WIDTH-1:0] mcand_r;
  logic signed [WIDTH:0]   mcand_ext;
  logic signed [WIDTH:0]   acc_sum;
  booth_op_t               op;

  always_comb begin
    mcand_ext = {mcand_i[WIDTH-1], mcand_i};
    op        = booth_decode(q_i[0], prev_i);
    case (op)
      BOOTH_ADD: acc_sum = acc_i + mcand_ext;
      BOOTH_SUB: acc_sum = acc_i - mcand_ext;
      default:   acc_sum = acc_i;
    endcase
    // arithmetic shift of the acc:q pair
    acc_nxt = {acc_sum[WIDTH], acc_sum[WIDTH:1]};
    q_nxt   = {acc_sum[0], q_i[WIDTH-1:1]};
  end

  // stage may load when empty or when its content moves on
  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      acc_r   <= acc_nxt;
      q_r     <= q_nxt;
      prev_r  <= q_i[0];
      mcand_r <= mcand_i;
    end
  end

  assign valid_o = valid_r;
  assign acc_o   = acc_r;
  assign q_o     = q_r;
  assign prev_o  = prev_r;
  assign mcand_o = mcand_r;

endmodule
